FILE: hdl/dgi_pkg.sv
`timescale 1ns / 1ps
package dgi_pkg;
    localparam int MAX_POINTS_DEF = 8;
    localparam logic [31:0] STALE_RESET = 32'd100000;
    localparam logic [12:0] UNITY_Q12 = 13'd4096;
    localparam logic [15:0] FIRST_DIST = 16'd50;
    localparam logic [15:0] LAST_DIST = 16'd4000;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;
endpackage

FILE: hdl/dgi_if.sv
`timescale 1ns / 1ps
interface dgi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [2:0]  point_index;
    logic [15:0] point_distance_mm;
    logic [15:0] point_gain;
    logic [3:0]  point_count;
    logic [3:0]  valid_flags;
    logic [15:0] left_mm;
    logic [15:0] center_mm;
    logic [15:0] right_mm;
    logic [31:0] generation;
    logic [63:0] sample_time_us;
    logic [63:0] now_us;
    modport source(output valid, operation, point_index, point_distance_mm, point_gain,
        point_count, valid_flags, left_mm, center_mm, right_mm, generation,
        sample_time_us, now_us, input ready);
    modport sink(input valid, operation, point_index, point_distance_mm, point_gain,
        point_count, valid_flags, left_mm, center_mm, right_mm, generation,
        sample_time_us, now_us, output ready);
endinterface

interface dgi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] generation_out;
    logic [63:0] timestamp_out;
    logic [12:0] left_gain;
    logic [12:0] right_gain;
    logic [12:0] top_gain;
    logic [12:0] bottom_gain;
    logic        geometry_usable;
    logic        fail_open;
    logic        curve_accepted;
    modport source(output valid, generation_out, timestamp_out, left_gain, right_gain,
        top_gain, bottom_gain, geometry_usable, fail_open, curve_accepted, input ready);
    modport sink(input valid, generation_out, timestamp_out, left_gain, right_gain,
        top_gain, bottom_gain, geometry_usable, fail_open, curve_accepted, output ready);
endinterface

interface dgi_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

FILE: hdl/distance_gain_interpolator_unit.sv
`timescale 1ns / 1ps
// Piecewise linear distance-to-gain lookup. One item at a time: a write is stored
// at once, a commit checks the staging points one per cycle and then copies them
// one per cycle, and an evaluate of usable geometry scans the segments one curve
// point per cycle and runs a 30-step restoring divider shared by left, right and
// center. The result is held in an output register; a new item is taken once
// that result has been taken.
module distance_gain_interpolator_unit
    import dgi_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dgi_in_if.sink   i_in,
    dgi_out_if.source o_out,
    dgi_cfg_if.sink  i_cfg
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_COPY, S_EVAL, S_SCAN, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [31:0] r_stale;
    logic [15:0] r_sd [MAX_POINTS];
    logic [15:0] r_sg [MAX_POINTS];
    logic [15:0] r_ld [MAX_POINTS];
    logic [12:0] r_lg [MAX_POINTS];
    logic [CW-1:0] r_lcnt;

    // captured item
    logic [3:0]  r_cnt;
    logic [3:0]  r_flags;
    logic [15:0] r_dist [3];
    logic [31:0] r_gen;
    logic [63:0] r_ts, r_now;

    logic [IW-1:0] r_idx;
    logic [1:0]  r_ch;       // 0 left, 1 right, 2 center
    logic [12:0] r_gain [3];
    logic [12:0] r_glo;
    logic [16:0] r_den;
    logic [29:0] r_num;      // numerator: up to 4096*65535 + 32767
    logic [29:0] r_quo;
    logic [16:0] r_rem;
    logic [4:0]  r_step;
    logic [4:0]  r_nsteps;

    logic r_ovalid;
    logic [31:0] r_ogen;
    logic [63:0] r_ots;
    logic [12:0] r_ol, r_or, r_oc;
    logic r_ousable, r_ofail, r_oacc;

    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.generation_out = r_ogen;
    assign o_out.timestamp_out  = r_ots;
    assign o_out.left_gain      = r_ol;
    assign o_out.right_gain     = r_or;
    assign o_out.top_gain       = r_oc;
    assign o_out.bottom_gain    = r_oc;
    assign o_out.geometry_usable = r_ousable;
    assign o_out.fail_open      = r_ofail;
    assign o_out.curve_accepted = r_oacc;

    // last live point index
    logic [IW-1:0] w_last;
    assign w_last = IW'(r_lcnt - CW'(1));
    logic [15:0] w_d;
    assign w_d = r_dist[r_ch];

    // freshness: 64-bit subtract and compare
    logic [63:0] w_age;
    logic w_fresh;
    assign w_age = r_now - r_ts;
    assign w_fresh = (r_ts != 64'd0) && (r_now >= r_ts) && (w_age <= {32'd0, r_stale});

    // staging point check at r_idx
    logic w_pt_ok;
    always_comb begin
        w_pt_ok = (r_sg[r_idx] <= 16'(UNITY_Q12));
        if (r_idx != '0) begin
            if (r_sd[r_idx] <= r_sd[r_idx - IW'(1)]) w_pt_ok = 1'b0;
            if (r_sg[r_idx] < r_sg[r_idx - IW'(1)]) w_pt_ok = 1'b0;
        end
    end

    // one restoring divide step
    logic [17:0] w_trial;
    always_comb begin
        w_trial = {r_rem, r_num[29]} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stale  <= STALE_RESET;
            r_ovalid <= 1'b0;
            r_lcnt   <= CW'(2);
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_sd[k] <= '0;
                r_sg[k] <= '0;
                r_ld[k] <= '0;
                r_lg[k] <= '0;
            end
            r_ld[0] <= FIRST_DIST;
            r_ld[1] <= LAST_DIST;
            r_lg[0] <= UNITY_Q12;
            r_lg[1] <= UNITY_Q12;
        end else begin
            if (o_out.ready && r_ovalid) r_ovalid <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) r_stale <= i_cfg.data;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && !r_ovalid) begin
                        r_cnt   <= i_in.point_count;
                        r_flags <= i_in.valid_flags;
                        r_dist[0] <= i_in.left_mm;
                        r_dist[1] <= i_in.right_mm;
                        r_dist[2] <= i_in.center_mm;
                        r_gen <= i_in.generation;
                        r_ts  <= i_in.sample_time_us;
                        r_now <= i_in.now_us;
                        r_ogen <= '0; r_ots <= '0;
                        r_ol <= '0; r_or <= '0; r_oc <= '0;
                        r_ousable <= 1'b0; r_ofail <= 1'b0;
                        // a write inside the staging range is accepted at once
                        r_oacc <= (t_op'(i_in.operation) == OP_WRITE) &&
                                  (32'(i_in.point_index) < 32'(MAX_POINTS));
                        r_idx <= '0;
                        r_ch  <= 2'd0;
                        case (t_op'(i_in.operation))
                            OP_WRITE: begin
                                if (32'(i_in.point_index) < 32'(MAX_POINTS)) begin
                                    r_sd[IW'(i_in.point_index)] <= i_in.point_distance_mm;
                                    r_sg[IW'(i_in.point_index)] <= i_in.point_gain;
                                end
                                r_state <= S_OUT;
                            end
                            OP_COMMIT: begin
                                if (i_in.point_count >= 4'd2 &&
                                    32'(i_in.point_count) <= 32'(MAX_POINTS))
                                    r_state <= S_CHECK;
                                else
                                    r_state <= S_OUT;
                            end
                            OP_EVAL: r_state <= S_EVAL;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_CHECK: begin
                    if (!w_pt_ok) begin
                        r_state <= S_OUT;
                    end else if (32'(r_idx) == 32'(r_cnt) - 1) begin
                        r_idx <= '0;
                        r_state <= S_COPY;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_COPY: begin
                    r_ld[r_idx] <= r_sd[r_idx];
                    r_lg[r_idx] <= r_sg[r_idx][12:0];
                    if (32'(r_idx) == 32'(r_cnt) - 1) begin
                        r_lcnt <= CW'(r_cnt);
                        r_oacc <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_EVAL: begin
                    r_ogen <= r_gen;
                    r_ots  <= r_ts;
                    if (r_flags == 4'hF && w_fresh) begin
                        r_ousable <= 1'b1;
                        r_idx <= IW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_ofail <= 1'b1;
                        r_ol <= UNITY_Q12; r_or <= UNITY_Q12; r_oc <= UNITY_Q12;
                        r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    // clamp, else find first point at or above d
                    if (w_d <= r_ld[0]) begin
                        r_gain[r_ch] <= r_lg[0];
                        r_state <= S_FIN;
                    end else if (w_d >= r_ld[w_last]) begin
                        r_gain[r_ch] <= r_lg[w_last];
                        r_state <= S_FIN;
                    end else if (w_d > r_ld[r_idx]) begin
                        r_idx <= r_idx + IW'(1);
                    end else begin
                        r_glo  <= r_lg[r_idx - IW'(1)];
                        r_den  <= 17'(r_ld[r_idx] - r_ld[r_idx - IW'(1)]);
                        r_num  <= 30'(32'(r_lg[r_idx] - r_lg[r_idx - IW'(1)]) *
                                      32'(w_d - r_ld[r_idx - IW'(1)]))
                                  + 30'((r_ld[r_idx] - r_ld[r_idx - IW'(1)]) >> 1);
                        r_quo  <= '0;
                        r_rem  <= '0;
                        r_step <= '0;
                        r_nsteps <= 5'd29;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!w_trial[17]) begin
                        r_rem <= w_trial[16:0];
                        r_quo <= {r_quo[28:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[15:0], r_num[29]};
                        r_quo <= {r_quo[28:0], 1'b0};
                    end
                    r_num <= {r_num[28:0], 1'b0};
                    r_step <= r_step + 5'd1;
                    if (r_step == r_nsteps) begin
                        r_gain[r_ch] <= 13'(({17'd0, r_glo} +
                            {r_quo[28:0], ~w_trial[17]}) > 30'(UNITY_Q12) ? UNITY_Q12 :
                            13'(30'(r_glo) + {r_quo[28:0], ~w_trial[17]}));
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_ch == 2'd2) begin
                        r_ol <= r_gain[0];
                        r_or <= r_gain[1];
                        r_oc <= r_gain[2];
                        r_state <= S_OUT;
                    end else begin
                        r_ch  <= r_ch + 2'd1;
                        r_idx <= IW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: dv/tb_distance_gain_interpolator_unit.sv
`timescale 1ns / 1ps
module tb_distance_gain_interpolator_unit;
    import dgi_pkg::*;

    localparam int NPTS = 8;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  point_index;
        logic [15:0] point_distance_mm;
        logic [15:0] point_gain;
        logic [3:0]  point_count;
        logic [3:0]  valid_flags;
        logic [15:0] left_mm;
        logic [15:0] center_mm;
        logic [15:0] right_mm;
        logic [31:0] generation;
        logic [63:0] sample_time_us;
        logic [63:0] now_us;
    } t_req;

    typedef struct packed {
        logic [31:0] generation_out;
        logic [63:0] timestamp_out;
        logic [12:0] left_gain;
        logic [12:0] right_gain;
        logic [12:0] top_gain;
        logic [12:0] bottom_gain;
        logic        geometry_usable;
        logic        fail_open;
        logic        curve_accepted;
    } t_gains;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dgi_in_if  in_ch();
    dgi_out_if out_ch();
    dgi_cfg_if cfg_ch();

    distance_gain_interpolator_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // predictor state
    logic [31:0] stale_limit;
    logic [15:0] stg_dist [NPTS];
    logic [15:0] stg_gain [NPTS];
    logic [15:0] cur_dist [NPTS];
    logic [15:0] cur_gain [NPTS];
    int unsigned cur_count;

    t_gains expected_gains[$];
    int     errors = 0;
    int     cycles = 0;
    bit     sink_idle_on = 1'b1;
    bit     src_idle_on = 1'b1;
    bit     hold_off = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[distance_gain_interpolator_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [12:0] curve_lookup(logic [15:0] d);
        logic [31:0] span, off;
        logic [63:0] v;
        if (cur_count < 2 || cur_count > NPTS) return UNITY_Q12;
        if (d <= cur_dist[0]) return cur_gain[0][12:0];
        if (d >= cur_dist[cur_count-1]) return cur_gain[cur_count-1][12:0];
        for (int i = 1; i < cur_count; i++) begin
            if (d > cur_dist[i]) continue;
            if (cur_dist[i] <= cur_dist[i-1] || cur_gain[i] < cur_gain[i-1])
                return UNITY_Q12;
            span = cur_dist[i] - cur_dist[i-1];
            off = d - cur_dist[i-1];
            v = cur_gain[i-1] + ((64'(cur_gain[i] - cur_gain[i-1]) * off + span / 2) / span);
            return (v > 4096) ? UNITY_Q12 : v[12:0];
        end
        return UNITY_Q12;
    endfunction

    function automatic bit staging_valid(int unsigned n);
        if (n < 2 || n > NPTS) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (stg_gain[i] > 4096) return 1'b0;
            if (i > 0 && (stg_dist[i] <= stg_dist[i-1] || stg_gain[i] < stg_gain[i-1]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_gains predict_gains(t_req r);
        t_gains g;
        bit fresh;
        g = '0;
        case (t_op'(r.operation))
            OP_WRITE: begin
                stg_dist[r.point_index] = r.point_distance_mm;
                stg_gain[r.point_index] = r.point_gain;
                g.curve_accepted = 1'b1;
            end
            OP_COMMIT: begin
                if (staging_valid(r.point_count)) begin
                    for (int i = 0; i < r.point_count; i++) begin
                        cur_dist[i] = stg_dist[i];
                        cur_gain[i] = stg_gain[i];
                    end
                    cur_count = r.point_count;
                    g.curve_accepted = 1'b1;
                end
            end
            OP_EVAL: begin
                fresh = r.sample_time_us != 0 && r.now_us >= r.sample_time_us &&
                        (r.now_us - r.sample_time_us) <= {32'd0, stale_limit};
                g.generation_out = r.generation;
                g.timestamp_out = r.sample_time_us;
                g.geometry_usable = (r.valid_flags == 4'hf) && fresh;
                if (!g.geometry_usable) begin
                    g.left_gain = UNITY_Q12;
                    g.right_gain = UNITY_Q12;
                    g.top_gain = UNITY_Q12;
                    g.bottom_gain = UNITY_Q12;
                    g.fail_open = 1'b1;
                end else begin
                    g.left_gain = curve_lookup(r.left_mm);
                    g.right_gain = curve_lookup(r.right_mm);
                    g.top_gain = curve_lookup(r.center_mm);
                    g.bottom_gain = g.top_gain;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // random idle bursts on the result side, plus the long hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_gains got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.generation_out, out_ch.timestamp_out, out_ch.left_gain,
                    out_ch.right_gain, out_ch.top_gain, out_ch.bottom_gain,
                    out_ch.geometry_usable, out_ch.fail_open, out_ch.curve_accepted};
            if (expected_gains.size() == 0) begin
                $error("unexpected result item");
                errors++;
            end else begin
                want = expected_gains.pop_front();
                if (got.generation_out !== want.generation_out) begin
                    $error("generation_out exp %0h got %0h", want.generation_out,
                           got.generation_out); errors++; end
                if (got.timestamp_out !== want.timestamp_out) begin
                    $error("timestamp_out exp %0h got %0h", want.timestamp_out,
                           got.timestamp_out); errors++; end
                if (got.left_gain !== want.left_gain) begin
                    $error("left_gain exp %0d got %0d", want.left_gain, got.left_gain);
                    errors++; end
                if (got.right_gain !== want.right_gain) begin
                    $error("right_gain exp %0d got %0d", want.right_gain, got.right_gain);
                    errors++; end
                if (got.top_gain !== want.top_gain) begin
                    $error("top_gain exp %0d got %0d", want.top_gain, got.top_gain);
                    errors++; end
                if (got.bottom_gain !== want.bottom_gain) begin
                    $error("bottom_gain exp %0d got %0d", want.bottom_gain, got.bottom_gain);
                    errors++; end
                if (got.geometry_usable !== want.geometry_usable) begin
                    $error("geometry_usable exp %0d got %0d", want.geometry_usable,
                           got.geometry_usable); errors++; end
                if (got.fail_open !== want.fail_open) begin
                    $error("fail_open exp %0d got %0d", want.fail_open, got.fail_open);
                    errors++; end
                if (got.curve_accepted !== want.curve_accepted) begin
                    $error("curve_accepted exp %0d got %0d", want.curve_accepted,
                           got.curve_accepted); errors++; end
            end
        end
    end

    // send one item, predicting at acceptance
    task automatic send_item(t_req r);
        if (src_idle_on && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        in_ch.valid <= 1'b1;
        {in_ch.operation, in_ch.point_index, in_ch.point_distance_mm, in_ch.point_gain,
         in_ch.point_count, in_ch.valid_flags, in_ch.left_mm, in_ch.center_mm,
         in_ch.right_mm, in_ch.generation, in_ch.sample_time_us, in_ch.now_us} <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_gains.push_back(predict_gains(r));
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_gains.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        stale_limit = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_req rand_item();
        t_req r;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom};
        r = raw[$bits(t_req)-1:0];
        return r;
    endfunction

    function automatic t_req write_req(int idx, int d, int g);
        t_req r;
        r = rand_item();
        r.operation = OP_WRITE;
        r.point_index = 3'(idx);
        r.point_distance_mm = 16'(d);
        r.point_gain = 16'(g);
        return r;
    endfunction

    function automatic t_req commit_req(int n);
        t_req r;
        r = rand_item();
        r.operation = OP_COMMIT;
        r.point_count = 4'(n);
        return r;
    endfunction

    // mostly fresh, fully valid geometry
    function automatic t_req eval_req(bit good);
        t_req r;
        r = rand_item();
        r.operation = OP_EVAL;
        if (good) begin
            r.valid_flags = 4'hf;
            r.sample_time_us = {$urandom, $urandom} | 64'd1;
            r.now_us = r.sample_time_us + $urandom_range(0, stale_limit > 200000 ?
                       200000 : stale_limit);
            if ($urandom_range(0, 1)) begin
                r.left_mm = 16'($urandom_range(0, 5000));
                r.center_mm = 16'($urandom_range(0, 5000));
                r.right_mm = 16'($urandom_range(0, 5000));
            end
        end
        return r;
    endfunction

    // load a monotonic curve through staging and commit it
    task automatic load_curve(int n);
        int d, g;
        d = $urandom_range(0, 500);
        g = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++) begin
            send_item(write_req(i, d, g));
            d += $urandom_range(1, 1500);
            g += $urandom_range(0, 700);
            if (g > 4096) g = 4096;
            if (d > 65535) d = 65535;
        end
        send_item(commit_req(n));
    endtask

    task automatic test_directed();
        t_req r;
        send_item(eval_req(1));
        r = eval_req(1); r.sample_time_us = 64'd0; send_item(r);
        r = eval_req(1); r.now_us = r.sample_time_us - 64'd1; send_item(r);
        r = eval_req(1); r.now_us = r.sample_time_us + 64'd100001; send_item(r);
        r = eval_req(1); r.now_us = r.sample_time_us + 64'd100000; send_item(r);
        r = eval_req(1); r.valid_flags = 4'h7; send_item(r);
        send_item(write_req(0, 0, 0));
        send_item(write_req(7, 65535, 4096));
        send_item(write_req(1, 65535, 65535));
        send_item(commit_req(2));
        send_item(commit_req(1));
        send_item(commit_req(15));
        send_item(write_req(1, 0, 100));
        send_item(commit_req(2));
        load_curve(8);
        r = eval_req(1); r.left_mm = 16'd0; r.center_mm = 16'd65535; r.right_mm = 16'd2000;
        send_item(r);
        r = rand_item(); r.operation = OP_NONE; send_item(r);
        send_item(commit_req(0));
        load_curve(2);
        r = eval_req(1); r.left_mm = 16'd0; r.center_mm = 16'd65535; send_item(r);
    endtask

    task automatic test_random(int n);
        int k;
        k = 0;
        while (k < n) begin
            case ($urandom_range(0, 9))
                0: begin load_curve($urandom_range(2, 8)); k += 9; end
                1: begin send_item(rand_item()); k++; end
                2: begin send_item(commit_req($urandom_range(0, 15))); k++; end
                3: begin
                    send_item(write_req($urandom_range(0, 7), $urandom, $urandom_range(0, 5000)));
                    k++;
                end
                default: begin send_item(eval_req($urandom_range(0, 7) != 0)); k++; end
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 10; i++) send_item(eval_req(1));
    endtask

    initial begin
        in_ch.valid = 1'b0;
        {in_ch.operation, in_ch.point_index, in_ch.point_distance_mm, in_ch.point_gain,
         in_ch.point_count, in_ch.valid_flags, in_ch.left_mm, in_ch.center_mm,
         in_ch.right_mm, in_ch.generation, in_ch.sample_time_us, in_ch.now_us} = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        stale_limit = STALE_RESET;
        for (int i = 0; i < NPTS; i++) begin
            stg_dist[i] = '0; stg_gain[i] = '0; cur_dist[i] = '0; cur_gain[i] = '0;
        end
        cur_dist[0] = FIRST_DIST; cur_dist[1] = LAST_DIST;
        cur_gain[0] = 16'd4096; cur_gain[1] = 16'd4096;
        cur_count = 2;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        wait_drained();
        write_timeout(32'd0);
        test_random(300);
        wait_drained();
        write_timeout(32'hffff_ffff);
        test_random(400);
        wait_drained();
        write_timeout($urandom_range(1000, 150000));
        test_random(300);
        wait_drained();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        test_random(250);
        wait_drained();

        if (errors == 0)
            $display("[distance_gain_interpolator_unit] OK");
        else
            $display("[distance_gain_interpolator_unit] ERROR");
        $finish;
    end
endmodule
